[sv/assert_macros.svh]
// Assertion macros shared by the torque vectoring differential RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TVD_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("torque vectoring assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define TVD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("torque vectoring assertion failed");

`endif

[sv/tvd_pkg.sv]
// Shared constants, types and tables of the torque vectoring differential.
package tvd_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned DivSteps = 20;
  localparam int unsigned DivNumW = 48;
  localparam int unsigned DivDenW = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgSteerGain = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTrackRatio = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgTorqueDeadband = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgAngleDeadband = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRatioMargin = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgTorqueLimit = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgSlipSlack = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpinThreshold = 3'd7;

  localparam logic [14:0] AngleSat = 15'd24576;
  localparam logic [19:0] RatioMax = 20'hFFFFF;
  localparam logic [19:0] RatioOne = 20'd4096;
  localparam logic signed [26:0] CordicX0 = 27'sd16777216;

  typedef struct packed {
    logic [15:0] steer_gain;
    logic [14:0] track_ratio;
    logic [14:0] torque_deadband;
    logic [13:0] angle_deadband;
    logic [11:0] ratio_margin;
    logic [14:0] torque_limit;
    logic [13:0] slip_slack;
    logic [14:0] spin_threshold;
  } cfg_t;

  function automatic logic [15:0] atan_entry(input int unsigned idx);
    logic [15:0] val;
    unique case (idx)
      0: val = 16'd51472;
      1: val = 16'd30385;
      2: val = 16'd16055;
      3: val = 16'd8150;
      4: val = 16'd4091;
      5: val = 16'd2047;
      6: val = 16'd1024;
      7: val = 16'd512;
      8: val = 16'd256;
      9: val = 16'd128;
      10: val = 16'd64;
      11: val = 16'd32;
      12: val = 16'd16;
      13: val = 16'd8;
      14: val = 16'd4;
      default: val = 16'd2;
    endcase
    return val;
  endfunction

endpackage

[sv/tvd_cfg.sv]
// Configuration register bank of the torque vectoring differential.
module tvd_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_en_i,
  input  logic [tvd_pkg::CfgIdxW-1:0]     wr_idx_i,
  input  logic [tvd_pkg::CfgDataW-1:0]    wr_data_i,
  output tvd_pkg::cfg_t                   cfg_o
);

  tvd_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.steer_gain      <= 16'd524;
      cfg_q.track_ratio     <= 15'd8192;
      cfg_q.torque_deadband <= 15'd128;
      cfg_q.angle_deadband  <= 14'd164;
      cfg_q.ratio_margin    <= 12'd410;
      cfg_q.torque_limit    <= 15'd25600;
      cfg_q.slip_slack      <= 14'd4506;
      cfg_q.spin_threshold  <= 15'd100;
    end else if (wr_en_i) begin
      unique case (wr_idx_i)
        tvd_pkg::CfgSteerGain:      cfg_q.steer_gain      <= wr_data_i;
        tvd_pkg::CfgTrackRatio:     cfg_q.track_ratio     <= wr_data_i[14:0];
        tvd_pkg::CfgTorqueDeadband: cfg_q.torque_deadband <= wr_data_i[14:0];
        tvd_pkg::CfgAngleDeadband:  cfg_q.angle_deadband  <= wr_data_i[13:0];
        tvd_pkg::CfgRatioMargin:    cfg_q.ratio_margin    <= wr_data_i[11:0];
        tvd_pkg::CfgTorqueLimit:    cfg_q.torque_limit    <= wr_data_i[14:0];
        tvd_pkg::CfgSlipSlack:      cfg_q.slip_slack      <= wr_data_i[13:0];
        tvd_pkg::CfgSpinThreshold:  cfg_q.spin_threshold  <= wr_data_i[14:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/tvd_cordic.sv]
// Pipelined CORDIC rotation, one step per stage, giving unnormalized sine and cosine.
module tvd_cordic (
  input  logic                clk_i,
  input  logic                adv_i,
  input  logic [16:0]         z_i,
  output logic signed [26:0]  x_o,
  output logic signed [26:0]  y_o
);

  logic signed [26:0] x_q [tvd_pkg::CordicSteps];
  logic signed [26:0] y_q [tvd_pkg::CordicSteps];
  logic signed [18:0] z_q [tvd_pkg::CordicSteps];

  for (genvar gi = 0; gi < tvd_pkg::CordicSteps; gi++) begin : g_step
    logic signed [26:0] x_in, y_in, x_d, y_d;
    logic signed [18:0] z_in, z_d, at;

    if (gi == 0) begin : g_first
      assign x_in = tvd_pkg::CordicX0;
      assign y_in = '0;
      assign z_in = $signed({2'b00, z_i});
    end else begin : g_next
      assign x_in = x_q[gi-1];
      assign y_in = y_q[gi-1];
      assign z_in = z_q[gi-1];
    end

    assign at = $signed({3'b000, tvd_pkg::atan_entry(gi)});

    always_comb begin
      if (!z_in[18]) begin
        x_d = x_in - (y_in >>> gi);
        y_d = y_in + (x_in >>> gi);
        z_d = z_in - at;
      end else begin
        x_d = x_in + (y_in >>> gi);
        y_d = y_in - (x_in >>> gi);
        z_d = z_in + at;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        x_q[gi] <= x_d;
        y_q[gi] <= y_d;
        z_q[gi] <= z_d;
      end
    end
  end

  assign x_o = x_q[tvd_pkg::CordicSteps-1];
  assign y_o = y_q[tvd_pkg::CordicSteps-1];

endmodule

[sv/tvd_div.sv]
// Pipelined restoring divider, one quotient bit per stage, for quotients below 2^20.
module tvd_div (
  input  logic                           clk_i,
  input  logic                           adv_i,
  input  logic [tvd_pkg::DivNumW-1:0]    a_i,
  input  logic [tvd_pkg::DivDenW-1:0]    b_i,
  output logic [tvd_pkg::DivSteps-1:0]   q_o
);

  localparam int unsigned ShW = tvd_pkg::DivDenW + tvd_pkg::DivSteps;

  logic [tvd_pkg::DivNumW-1:0]  rem_q [tvd_pkg::DivSteps];
  logic [tvd_pkg::DivDenW-1:0]  den_q [tvd_pkg::DivSteps];
  logic [tvd_pkg::DivSteps-1:0] quo_q [tvd_pkg::DivSteps];

  for (genvar gi = 0; gi < tvd_pkg::DivSteps; gi++) begin : g_step
    localparam int unsigned Bit = tvd_pkg::DivSteps - 1 - gi;
    logic [tvd_pkg::DivNumW-1:0]  rem_in, rem_d;
    logic [tvd_pkg::DivDenW-1:0]  den_in;
    logic [tvd_pkg::DivSteps-1:0] quo_in, quo_d;
    logic [ShW-1:0]               sh;
    logic                         take;

    if (gi == 0) begin : g_first
      assign rem_in = a_i;
      assign den_in = b_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[gi-1];
      assign den_in = den_q[gi-1];
      assign quo_in = quo_q[gi-1];
    end

    always_comb begin
      sh = ShW'(den_in) << Bit;
      take = ShW'(rem_in) >= sh;
      rem_d = take ? rem_in - sh[tvd_pkg::DivNumW-1:0] : rem_in;
      quo_d = quo_in;
      quo_d[Bit] = take;
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[gi] <= rem_d;
        den_q[gi] <= den_in;
        quo_q[gi] <= quo_d;
      end
    end
  end

  assign q_o = quo_q[tvd_pkg::DivSteps-1];

endmodule

[sv/torque_vectoring_differential_top.sv]
// Top level of the torque vectoring differential pipeline.
// One item enters per cycle while no output stall holds the pipeline. The pipeline is
// a 16-stage CORDIC for the tangent, a 20-stage divider for the tangent
// quotient, a second 20-stage divider bank for the wheel torques and the split
// ratio, and ten stages of scaling, products and slip compares. An output stall
// freezes the whole pipeline, so nothing is lost or repeated.
`include "assert_macros.svh"

module torque_vectoring_differential_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tvd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tvd_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [15:0]            torque_request_i,
  input  logic signed [11:0]            steer_position_i,
  input  logic signed [15:0]            left_speed_i,
  input  logic signed [15:0]            right_speed_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [14:0]                   left_torque_o,
  output logic [14:0]                   right_torque_o,
  output logic [19:0]                   split_ratio_o,
  output logic                          slip_left_o,
  output logic                          slip_right_o
);

  typedef struct packed {
    logic signed [15:0] trq;
    logic               pos_pos;
    logic               tdb_ok;
    logic               ang_ok;
    logic signed [15:0] ls;
    logic signed [15:0] rs;
  } side_a_t;

  typedef struct packed {
    side_a_t s;
    logic    lim_sel;
    logic    zero_sel;
  } side_b_t;

  typedef struct packed {
    logic               cap_l;
    logic               cap_r;
    logic               zz;
    logic               q_over;
    logic               q_one;
    logic signed [15:0] ls;
    logic signed [15:0] rs;
  } side_c_t;

  tvd_pkg::cfg_t cfg;
  logic adv;
  logic [14:0] lim;

  tvd_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_we_i),
    .wr_idx_i  (cfg_idx_i),
    .wr_data_i (cfg_wdata_i),
    .cfg_o     (cfg)
  );

  logic out_v_q;
  assign adv = !(out_v_q && out_stall_i);
  assign in_stall_o = !adv;
  assign lim = (cfg.track_ratio > {3'b000, cfg.ratio_margin}) ?
               cfg.track_ratio - {3'b000, cfg.ratio_margin} : '0;

  // Stage 1: magnitudes and steering product.
  logic [11:0] pos_u, pos_mag;
  logic [15:0] trq_u, trq_mag;
  side_a_t side1_d, side1_q, side2_d, side2_q;
  logic [27:0] prod1_d, prod1_q;
  logic v1_q;

  always_comb begin
    pos_u = steer_position_i;
    trq_u = torque_request_i;
    pos_mag = pos_u[11] ? ~pos_u + 12'd1 : pos_u;
    trq_mag = trq_u[15] ? ~trq_u + 16'd1 : trq_u;
    prod1_d = 28'(pos_mag) * 28'(cfg.steer_gain);
    side1_d.trq = torque_request_i;
    side1_d.pos_pos = !pos_u[11] && (pos_u != '0);
    side1_d.tdb_ok = trq_mag >= {1'b0, cfg.torque_deadband};
    side1_d.ang_ok = 1'b0;
    side1_d.ls = left_speed_i;
    side1_d.rs = right_speed_i;
  end

  // Stage 2: saturated angle and deadband.
  logic [25:0] prod_sh;
  logic [14:0] ang;
  logic [16:0] z2_q;
  logic v2_q;

  always_comb begin
    prod_sh = prod1_q[27:2];
    ang = (prod_sh > 26'(tvd_pkg::AngleSat)) ? tvd_pkg::AngleSat : prod_sh[14:0];
    side2_d = side1_q;
    side2_d.ang_ok = ang >= {1'b0, cfg.angle_deadband};
  end

  // CORDIC stages.
  logic signed [26:0] cx, cy;
  side_a_t sc_q [tvd_pkg::CordicSteps];
  logic [tvd_pkg::CordicSteps-1:0] vc_q;

  tvd_cordic u_cordic (
    .clk_i (clk_i),
    .adv_i (adv),
    .z_i   (z2_q),
    .x_o   (cx),
    .y_o   (cy)
  );

  // Tangent quotient.
  side_b_t st_d;
  side_b_t st_q [tvd_pkg::DivSteps];
  logic [tvd_pkg::DivSteps-1:0] vt_q;
  logic [tvd_pkg::DivNumW-1:0] tan_a;
  logic [tvd_pkg::DivDenW-1:0] tan_b;
  logic [tvd_pkg::DivSteps-1:0] tan_q;

  always_comb begin
    st_d.s = sc_q[tvd_pkg::CordicSteps-1];
    st_d.lim_sel = (cx <= 27'sd0) || ((cy > 27'sd0) && (30'(cy) >= (30'(cx) <<< 3)));
    st_d.zero_sel = !st_d.lim_sel && (cy <= 27'sd0);
    tan_a = {9'b0, cy, 12'b0};
    tan_b = {5'b0, cx};
  end

  tvd_div u_div_tan (
    .clk_i (clk_i),
    .adv_i (adv),
    .a_i   (tan_a),
    .b_i   (tan_b),
    .q_o   (tan_q)
  );

  // Numerator and denominator of the split.
  side_b_t sb;
  logic [14:0] tcl, tv, tu_d;
  logic [15:0] rp, tp, num_d, den_d;
  logic zz_d;
  logic [15:0] num_q, den_q;
  logic [14:0] tu_q;
  logic zz_q, vnd_q;
  logic signed [15:0] ls_nd_q, rs_nd_q;

  always_comb begin
    sb = st_q[tvd_pkg::DivSteps-1];
    tcl = (tan_q > 20'(lim)) ? lim : tan_q[14:0];
    tv = sb.lim_sel ? lim : (sb.zero_sel ? '0 : tcl);
    rp = {1'b0, cfg.track_ratio};
    tp = {1'b0, tv};
    if (!(sb.s.tdb_ok && sb.s.ang_ok)) begin
      num_d = 16'd1;
      den_d = 16'd1;
    end else if (sb.s.pos_pos) begin
      num_d = rp + tp;
      den_d = rp - tp;
    end else begin
      num_d = rp - tp;
      den_d = rp + tp;
    end
    zz_d = !sb.s.tdb_ok || sb.s.trq[15] || (sb.s.trq == '0) ||
           (num_d == '0) || (den_d == '0);
    tu_d = sb.s.trq[14:0];
  end

  // Products stage.
  logic [28:0] ra_d, ra_p1_q, ra_p2_q;
  logic q_over_d, q_one_d;
  logic [30:0] m_tn_q, m_td_q, m_ln_q, m_ld_q;
  logic [31:0] nn_q, dd_q;
  logic [15:0] num_p1_q, den_p1_q;
  logic zz_p1_q, q_over_p1_q, q_one_p1_q, vp1_q;
  logic signed [15:0] ls_p1_q, rs_p1_q;

  always_comb begin
    ra_d = {1'b0, num_q, 12'b0} + 29'(den_q >> 1);
    q_over_d = (den_q == '0) || (36'(ra_d) >= {den_q, 20'b0});
    q_one_d = (den_q == '0) && (num_q == '0);
  end

  // Cap decision and squared products.
  logic cap_l_d, cap_r_d;
  logic [46:0] lnn_d, ldd_d;
  logic cap_l_q, cap_r_q;
  logic [46:0] lnn_q, ldd_q;
  logic [30:0] m_tn_p2_q, m_td_p2_q;
  logic [31:0] nn_p2_q, dd_p2_q;
  logic [15:0] num_p2_q, den_p2_q;
  logic zz_p2_q, q_over_p2_q, q_one_p2_q, vp2_q;
  logic signed [15:0] ls_p2_q, rs_p2_q;

  always_comb begin
    cap_l_d = (num_p1_q >= den_p1_q) && (m_tn_q > m_ld_q);
    cap_r_d = (num_p1_q < den_p1_q) && (m_td_q > m_ln_q);
    lnn_d = 47'(m_ln_q) * 47'(num_p1_q);
    ldd_d = 47'(m_ld_q) * 47'(den_p1_q);
  end

  // Torque and ratio dividers.
  logic [tvd_pkg::DivNumW-1:0] l_div_a, r_div_a, q_div_a;
  logic [tvd_pkg::DivDenW-1:0] l_div_b, r_div_b, q_div_b;
  logic [tvd_pkg::DivSteps-1:0] l_quo, r_quo, q_quo;
  side_c_t sd_d;
  side_c_t sd_q [tvd_pkg::DivSteps];
  logic [tvd_pkg::DivSteps-1:0] vd_q;

  always_comb begin
    l_div_a = cap_r_q ? {1'b0, lnn_q} : {17'b0, m_tn_p2_q};
    l_div_b = cap_r_q ? dd_p2_q : {16'b0, den_p2_q};
    r_div_a = cap_l_q ? {1'b0, ldd_q} : {17'b0, m_td_p2_q};
    r_div_b = cap_l_q ? nn_p2_q : {16'b0, num_p2_q};
    q_div_a = {19'b0, ra_p2_q};
    q_div_b = {16'b0, den_p2_q};
    sd_d.cap_l = cap_l_q;
    sd_d.cap_r = cap_r_q;
    sd_d.zz = zz_p2_q;
    sd_d.q_over = q_over_p2_q;
    sd_d.q_one = q_one_p2_q;
    sd_d.ls = ls_p2_q;
    sd_d.rs = rs_p2_q;
  end

  tvd_div u_div_left (
    .clk_i (clk_i),
    .adv_i (adv),
    .a_i   (l_div_a),
    .b_i   (l_div_b),
    .q_o   (l_quo)
  );

  tvd_div u_div_right (
    .clk_i (clk_i),
    .adv_i (adv),
    .a_i   (r_div_a),
    .b_i   (r_div_b),
    .q_o   (r_quo)
  );

  tvd_div u_div_ratio (
    .clk_i (clk_i),
    .adv_i (adv),
    .a_i   (q_div_a),
    .b_i   (q_div_b),
    .q_o   (q_quo)
  );

  // Torque selection, zero rule and split ratio.
  side_c_t sdl;
  logic [14:0] lp, rp_t, lz, rz;
  logic [19:0] q_d;
  logic spin_d;
  logic [14:0] l_q1_q, r_q1_q;
  logic [19:0] q_q1_q;
  logic spin_q1_q, vq1_q;
  logic signed [15:0] ls_q1_q, rs_q1_q;

  always_comb begin
    sdl = sd_q[tvd_pkg::DivSteps-1];
    lp = sdl.cap_l ? cfg.torque_limit : l_quo[14:0];
    rp_t = sdl.cap_r ? cfg.torque_limit : r_quo[14:0];
    if (sdl.zz || (lp == '0) || (rp_t == '0)) begin
      lz = '0;
      rz = '0;
    end else begin
      lz = lp;
      rz = rp_t;
    end
    q_d = sdl.q_over ? (sdl.q_one ? tvd_pkg::RatioOne : tvd_pkg::RatioMax) : q_quo;
    spin_d = (sdl.ls > $signed({1'b0, cfg.spin_threshold})) ||
             (sdl.rs > $signed({1'b0, cfg.spin_threshold}));
  end

  // Ratio squared.
  logic [39:0] qq;
  logic [27:0] r2_q;
  logic [14:0] l_q2_q, r_q2_q;
  logic [19:0] q_q2_q;
  logic spin_q2_q, vq2_q;
  logic signed [15:0] ls_q2_q, rs_q2_q;

  assign qq = 40'(q_q1_q) * 40'(q_q1_q);

  // Slip products.
  logic [41:0] r2sk_d, r2sk_q;
  logic signed [30:0] ls_sk_d, ls_sk_q;
  logic signed [44:0] rs_r2_d, rs_r2_q;
  logic [14:0] l_q3_q, r_q3_q;
  logic [19:0] q_q3_q;
  logic spin_q3_q, vq3_q;
  logic signed [15:0] ls_q3_q, rs_q3_q;

  always_comb begin
    r2sk_d = 42'(r2_q) * 42'(cfg.slip_slack);
    ls_sk_d = 31'(ls_q2_q) * 31'($signed({1'b0, cfg.slip_slack}));
    rs_r2_d = 45'(rs_q2_q) * 45'($signed({1'b0, r2_q}));
  end

  logic signed [37:0] p_lo_d, p_hi_d, p_lo_q, p_hi_q;
  logic sr_d, sr_q;
  logic [14:0] l_q4_q, r_q4_q;
  logic [19:0] q_q4_q;
  logic spin_q4_q, vq4_q;
  logic signed [15:0] ls_q4_q;

  always_comb begin
    p_lo_d = 38'(rs_q3_q) * 38'($signed({1'b0, r2sk_q[20:0]}));
    p_hi_d = 38'(rs_q3_q) * 38'($signed({1'b0, r2sk_q[41:21]}));
    sr_d = spin_q3_q && (45'(ls_sk_q) < rs_r2_q);
  end

  // Final compare and output register.
  logic signed [59:0] rhs, lhs;
  logic sl_d;
  logic [14:0] left_torque_q, right_torque_q;
  logic [19:0] split_ratio_q;
  logic slip_left_q, slip_right_q;

  always_comb begin
    rhs = (60'(p_hi_q) <<< 21) + 60'(p_lo_q);
    lhs = 60'(ls_q4_q) <<< 24;
    sl_d = spin_q4_q && (lhs > rhs);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vc_q <= '0;
      vt_q <= '0;
      vnd_q <= 1'b0;
      vp1_q <= 1'b0;
      vp2_q <= 1'b0;
      vd_q <= '0;
      vq1_q <= 1'b0;
      vq2_q <= 1'b0;
      vq3_q <= 1'b0;
      vq4_q <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      vc_q <= {vc_q[tvd_pkg::CordicSteps-2:0], v2_q};
      vt_q <= {vt_q[tvd_pkg::DivSteps-2:0], vc_q[tvd_pkg::CordicSteps-1]};
      vnd_q <= vt_q[tvd_pkg::DivSteps-1];
      vp1_q <= vnd_q;
      vp2_q <= vp1_q;
      vd_q <= {vd_q[tvd_pkg::DivSteps-2:0], vp2_q};
      vq1_q <= vd_q[tvd_pkg::DivSteps-1];
      vq2_q <= vq1_q;
      vq3_q <= vq2_q;
      vq4_q <= vq3_q;
      out_v_q <= vq4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side1_q <= side1_d;
      prod1_q <= prod1_d;
      side2_q <= side2_d;
      z2_q <= {ang, 2'b00};
      sc_q[0] <= side2_q;
      for (int i = 1; i < tvd_pkg::CordicSteps; i++) begin
        sc_q[i] <= sc_q[i-1];
      end
      st_q[0] <= st_d;
      for (int i = 1; i < tvd_pkg::DivSteps; i++) begin
        st_q[i] <= st_q[i-1];
      end
      num_q <= num_d;
      den_q <= den_d;
      tu_q <= tu_d;
      zz_q <= zz_d;
      ls_nd_q <= sb.s.ls;
      rs_nd_q <= sb.s.rs;
      m_tn_q <= 31'(tu_q) * 31'(num_q);
      m_td_q <= 31'(tu_q) * 31'(den_q);
      m_ln_q <= 31'(cfg.torque_limit) * 31'(num_q);
      m_ld_q <= 31'(cfg.torque_limit) * 31'(den_q);
      nn_q <= 32'(num_q) * 32'(num_q);
      dd_q <= 32'(den_q) * 32'(den_q);
      num_p1_q <= num_q;
      den_p1_q <= den_q;
      zz_p1_q <= zz_q;
      ra_p1_q <= ra_d;
      q_over_p1_q <= q_over_d;
      q_one_p1_q <= q_one_d;
      ls_p1_q <= ls_nd_q;
      rs_p1_q <= rs_nd_q;
      cap_l_q <= cap_l_d;
      cap_r_q <= cap_r_d;
      lnn_q <= lnn_d;
      ldd_q <= ldd_d;
      m_tn_p2_q <= m_tn_q;
      m_td_p2_q <= m_td_q;
      nn_p2_q <= nn_q;
      dd_p2_q <= dd_q;
      num_p2_q <= num_p1_q;
      den_p2_q <= den_p1_q;
      zz_p2_q <= zz_p1_q;
      ra_p2_q <= ra_p1_q;
      q_over_p2_q <= q_over_p1_q;
      q_one_p2_q <= q_one_p1_q;
      ls_p2_q <= ls_p1_q;
      rs_p2_q <= rs_p1_q;
      sd_q[0] <= sd_d;
      for (int i = 1; i < tvd_pkg::DivSteps; i++) begin
        sd_q[i] <= sd_q[i-1];
      end
      l_q1_q <= lz;
      r_q1_q <= rz;
      q_q1_q <= q_d;
      spin_q1_q <= spin_d;
      ls_q1_q <= sdl.ls;
      rs_q1_q <= sdl.rs;
      r2_q <= qq[39:12];
      l_q2_q <= l_q1_q;
      r_q2_q <= r_q1_q;
      q_q2_q <= q_q1_q;
      spin_q2_q <= spin_q1_q;
      ls_q2_q <= ls_q1_q;
      rs_q2_q <= rs_q1_q;
      r2sk_q <= r2sk_d;
      ls_sk_q <= ls_sk_d;
      rs_r2_q <= rs_r2_d;
      l_q3_q <= l_q2_q;
      r_q3_q <= r_q2_q;
      q_q3_q <= q_q2_q;
      spin_q3_q <= spin_q2_q;
      ls_q3_q <= ls_q2_q;
      rs_q3_q <= rs_q2_q;
      p_lo_q <= p_lo_d;
      p_hi_q <= p_hi_d;
      sr_q <= sr_d;
      l_q4_q <= l_q3_q;
      r_q4_q <= r_q3_q;
      q_q4_q <= q_q3_q;
      spin_q4_q <= spin_q3_q;
      ls_q4_q <= ls_q3_q;
      left_torque_q <= sl_d ? '0 : l_q4_q;
      right_torque_q <= sr_q ? '0 : r_q4_q;
      split_ratio_q <= q_q4_q;
      slip_left_q <= sl_d;
      slip_right_q <= sr_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign left_torque_o = left_torque_q;
  assign right_torque_o = right_torque_q;
  assign split_ratio_o = split_ratio_q;
  assign slip_left_o = slip_left_q;
  assign slip_right_o = slip_right_q;

  `TVD_ASSERT_IMPL(a_slip_left_cut, clk_i, rst_ni, out_v_q && slip_left_q, left_torque_q == '0)
  `TVD_ASSERT_IMPL(a_slip_right_cut, clk_i, rst_ni, out_v_q && slip_right_q, right_torque_q == '0)
  `TVD_ASSERT_IMPL(a_zero_pair, clk_i, rst_ni, out_v_q && !slip_left_q && !slip_right_q && left_torque_q == '0, right_torque_q == '0)
  `TVD_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, out_v_q && out_stall_i, out_v_q)

endmodule

[tb/tb_torque_vectoring_differential_top.sv]
// Self-checking testbench for the torque vectoring differential top level.
`timescale 1ns / 100ps

module tb_torque_vectoring_differential_top;

  typedef struct packed {
    logic [14:0] left_torque;
    logic [14:0] right_torque;
    logic [19:0] split_ratio;
    logic        slip_left;
    logic        slip_right;
  } split_t;

  typedef struct packed {
    logic signed [15:0] trq;
    logic signed [11:0] pos;
    logic signed [15:0] lspd;
    logic signed [15:0] rspd;
    logic               typed;
    split_t             res;
  } row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [tvd_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [tvd_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic signed [15:0]           torque_request_i = '0;
  logic signed [11:0]           steer_position_i = '0;
  logic signed [15:0]           left_speed_i = '0;
  logic signed [15:0]           right_speed_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [14:0]                  left_torque_o;
  logic [14:0]                  right_torque_o;
  logic [19:0]                  split_ratio_o;
  logic                         slip_left_o;
  logic                         slip_right_o;

  tvd_pkg::cfg_t cfg_copy;
  split_t pending_splits[$];
  int     fail_count = 0;
  int     cycle_count = 0;
  bit     idle_free = 1'b0;

  torque_vectoring_differential_top dut (.*);

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic longint tangent_q12(input longint z, input longint lim);
    longint x;
    longint y;
    longint dx;
    longint dy;
    longint t;
    x = longint'(1) << 24;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(tvd_pkg::atan_entry(i));
      end else begin
        x += dx;
        y -= dy;
        z += longint'(tvd_pkg::atan_entry(i));
      end
    end
    if (x <= 0) return lim;
    if (y <= 0) return 0;
    t = (y * 4096) / x;
    return (t > lim) ? lim : t;
  endfunction

  function automatic split_t predict_split(input logic signed [15:0] trq,
                                           input logic signed [11:0] pos,
                                           input logic signed [15:0] lspd,
                                           input logic signed [15:0] rspd);
    longint tq, ps, ls, rs, num, den, q, r2, lt, rt, pm, ang, lim, t, lmt, sk, thr;
    logic sl, sr;
    split_t res;
    tq = trq;
    ps = pos;
    ls = lspd;
    rs = rspd;
    num = 1;
    den = 1;
    lt = 0;
    rt = 0;
    sl = 1'b0;
    sr = 1'b0;
    lmt = cfg_copy.torque_limit;
    if ((tq < 0 ? -tq : tq) >= longint'(cfg_copy.torque_deadband)) begin
      pm = ps < 0 ? -ps : ps;
      ang = (pm * longint'(cfg_copy.steer_gain)) >> 2;
      if (ang > 24576) ang = 24576;
      if (ang >= longint'(cfg_copy.angle_deadband)) begin
        lim = longint'(cfg_copy.track_ratio) - longint'(cfg_copy.ratio_margin);
        if (lim < 0) lim = 0;
        t = tangent_q12(ang << 2, lim);
        if (ps > 0) begin
          num = cfg_copy.track_ratio + t;
          den = cfg_copy.track_ratio - t;
        end else begin
          num = cfg_copy.track_ratio - t;
          den = cfg_copy.track_ratio + t;
        end
      end
      if (tq > 0 && num != 0 && den != 0) begin
        if (num >= den && tq * num > lmt * den) begin
          lt = lmt;
          rt = lmt * den * den / (num * num);
        end else if (num < den && tq * den > lmt * num) begin
          rt = lmt;
          lt = lmt * num * num / (den * den);
        end else begin
          lt = tq * num / den;
          rt = tq * den / num;
        end
        if (lt == 0 || rt == 0) begin
          lt = 0;
          rt = 0;
        end
      end
    end
    if (den == 0) begin
      q = (num == 0) ? 4096 : 1048575;
    end else begin
      q = (num * 4096 + den / 2) / den;
      if (q > 1048575) q = 1048575;
    end
    r2 = (q * q) >> 12;
    sk = cfg_copy.slip_slack;
    thr = cfg_copy.spin_threshold;
    if (ls > thr || rs > thr) begin
      sr = ls * sk < rs * r2;
      sl = ls * (longint'(1) << 24) > rs * r2 * sk;
    end
    if (sl) lt = 0;
    if (sr) rt = 0;
    res.left_torque = lt[14:0];
    res.right_torque = rt[14:0];
    res.split_ratio = q[19:0];
    res.slip_left = sl;
    res.slip_right = sr;
    return res;
  endfunction

  always @(posedge clk_i) begin
    split_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_splits.size() == 0) begin
        $error("unexpected result item");
        fail_count++;
      end else begin
        want = pending_splits.pop_front();
        if (left_torque_o !== want.left_torque) begin
          $error("left_torque expected %0d got %0d", want.left_torque, left_torque_o);
          fail_count++;
        end
        if (right_torque_o !== want.right_torque) begin
          $error("right_torque expected %0d got %0d", want.right_torque, right_torque_o);
          fail_count++;
        end
        if (split_ratio_o !== want.split_ratio) begin
          $error("split_ratio expected %0d got %0d", want.split_ratio, split_ratio_o);
          fail_count++;
        end
        if (slip_left_o !== want.slip_left) begin
          $error("slip_left expected %0d got %0d", want.slip_left, slip_left_o);
          fail_count++;
        end
        if (slip_right_o !== want.slip_right) begin
          $error("slip_right expected %0d got %0d", want.slip_right, slip_right_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_free || cycle_count % 500 < 100) begin
      out_stall_i <= 1'b0;
    end else begin
      case ((cycle_count / 37) % 3)
        0: out_stall_i <= ($urandom_range(0, 3) == 0);
        1: out_stall_i <= ($urandom_range(0, 1) == 0);
        default: out_stall_i <= (cycle_count % 7 < 5);
      endcase
    end
  end

  task automatic write_reg(input logic [tvd_pkg::CfgIdxW-1:0] idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val[15:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tvd_pkg::CfgSteerGain: cfg_copy.steer_gain = val[15:0];
      tvd_pkg::CfgTrackRatio: cfg_copy.track_ratio = val[14:0];
      tvd_pkg::CfgTorqueDeadband: cfg_copy.torque_deadband = val[14:0];
      tvd_pkg::CfgAngleDeadband: cfg_copy.angle_deadband = val[13:0];
      tvd_pkg::CfgRatioMargin: cfg_copy.ratio_margin = val[11:0];
      tvd_pkg::CfgTorqueLimit: cfg_copy.torque_limit = val[14:0];
      tvd_pkg::CfgSlipSlack: cfg_copy.slip_slack = val[13:0];
      default: cfg_copy.spin_threshold = val[14:0];
    endcase
  endtask

  task automatic load_regs(input int unsigned sg, tr, tdb, adb, rm, tl, ss, st);
    write_reg(tvd_pkg::CfgSteerGain, sg);
    write_reg(tvd_pkg::CfgTrackRatio, tr);
    write_reg(tvd_pkg::CfgTorqueDeadband, tdb);
    write_reg(tvd_pkg::CfgAngleDeadband, adb);
    write_reg(tvd_pkg::CfgRatioMargin, rm);
    write_reg(tvd_pkg::CfgTorqueLimit, tl);
    write_reg(tvd_pkg::CfgSlipSlack, ss);
    write_reg(tvd_pkg::CfgSpinThreshold, st);
  endtask

  int burst_left = 0;

  task automatic send_item(input row_t row);
    int gap;
    if (!idle_free && burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid_i <= 1'b1;
    torque_request_i <= row.trq;
    steer_position_i <= row.pos;
    left_speed_i <= row.lspd;
    right_speed_i <= row.rspd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (row.typed) pending_splits.push_back(row.res);
    else pending_splits.push_back(predict_split(row.trq, row.pos, row.lspd, row.rspd));
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_splits.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic row_t random_row;
    row_t row;
    int base;
    row.typed = 1'b0;
    row.res = '0;
    case ($urandom_range(0, 3))
      0: row.trq = 16'($urandom);
      1: row.trq = 16'($urandom_range(0, 400));
      default: row.trq = 16'($urandom_range(0, 32767));
    endcase
    row.pos = 12'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      row.lspd = 16'($urandom);
      row.rspd = 16'($urandom);
    end else begin
      base = int'($urandom_range(0, 6000));
      row.lspd = 16'(base);
      row.rspd = 16'(base + int'($urandom_range(0, 3000)) - 1500);
    end
    return row;
  endfunction

  localparam split_t Neutral = '{15'd0, 15'd0, 20'd4096, 1'b0, 1'b0};

  row_t directed[] = '{
    '{16'sd0, 12'sd0, 16'sd0, 16'sd0, 1'b1, Neutral},
    '{16'sd100, 12'sd2047, 16'sd0, 16'sd0, 1'b1, Neutral},
    '{-16'sd100, -12'sd2048, -16'sd32768, -16'sd32768, 1'b1, Neutral},
    '{16'sd32767, 12'sd0, 16'sd1000, 16'sd1000, 1'b0, Neutral},
    '{-16'sd32768, 12'sd2047, 16'sd1000, 16'sd1000, 1'b0, Neutral},
    '{16'sd32767, 12'sd2047, 16'sd32767, 16'sd32767, 1'b0, Neutral},
    '{16'sd32767, -12'sd2048, 16'sd32767, -16'sd32768, 1'b0, Neutral},
    '{16'sd5000, 12'sd1, 16'sd500, 16'sd500, 1'b0, Neutral},
    '{16'sd5000, -12'sd1, 16'sd500, 16'sd500, 1'b0, Neutral},
    '{16'sd5000, 12'sd300, 16'sd500, 16'sd400, 1'b0, Neutral},
    '{16'sd5000, -12'sd300, 16'sd400, 16'sd500, 1'b0, Neutral},
    '{16'sd128, 12'sd500, 16'sd2000, 16'sd100, 1'b0, Neutral},
    '{16'sd127, 12'sd500, 16'sd100, 16'sd2000, 1'b0, Neutral},
    '{16'sd1, 12'sd1000, 16'sd200, 16'sd200, 1'b0, Neutral},
    '{16'sd20000, 12'sd800, -16'sd32768, 16'sd32767, 1'b0, Neutral},
    '{16'sd20000, -12'sd800, 16'sd101, 16'sd100, 1'b0, Neutral}
  };

  initial begin
    cfg_copy = '{16'd524, 15'd8192, 15'd128, 14'd164, 12'd410, 15'd25600,
                 14'd4506, 15'd100};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed[i]) send_item(directed[i]);
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: load_regs(524, 8192, 128, 164, 410, 25600, 4506, 100);
        1: load_regs(65535, 4096, 0, 0, 0, 32767, 4096, 0);
        2: load_regs(65535, 4096, 0, 0, 0, 0, 4096, 0);
        3: load_regs(0, 32767, 25600, 16383, 4095, 32767, 16383, 32767);
        default: load_regs($urandom_range(0, 65535), $urandom_range(4096, 32767),
                           $urandom_range(0, 2000), $urandom_range(0, 16383),
                           $urandom_range(0, 4095), $urandom_range(0, 32767),
                           $urandom_range(4096, 16383), $urandom_range(0, 3000));
      endcase
      idle_free = (phase == 4);
      foreach (directed[i]) begin
        if (phase == 1) send_item('{directed[i].trq, directed[i].pos,
                                    directed[i].lspd, directed[i].rspd, 1'b0, Neutral});
      end
      repeat (200) send_item(random_row());
    end
    drain();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
